@@ hw/rtl/qepl_pkg.sv @@
`timescale 1ns / 1ps

package qepl_pkg;

  // Tick counter width and the number of ticks that make one detent.
  localparam int unsigned TICK_WIDTH        = 32;
  localparam int unsigned COUNTS_PER_DETENT = 2;

  localparam int unsigned REM_W       = (COUNTS_PER_DETENT > 1) ? $clog2(COUNTS_PER_DETENT) : 1;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef logic [TICK_WIDTH-1:0] tick_quo_t;
  typedef logic [REM_W-1:0]      tick_rem_t;

  // The tick count is held in sign and magnitude form, with the magnitude
  // kept as a quotient and remainder of the detent size.
  typedef struct packed {
    logic      neg;
    tick_quo_t quo;
    tick_rem_t rem;
  } tick_t;

  localparam tick_quo_t MAG_NEG_MIN = {1'b1, {(TICK_WIDTH-1){1'b0}}};
  localparam tick_quo_t MAG_POS_MAX = {1'b0, {(TICK_WIDTH-1){1'b1}}};

  localparam tick_quo_t QUO_NEG_MIN = tick_quo_t'(MAG_NEG_MIN / COUNTS_PER_DETENT);
  localparam tick_rem_t REM_NEG_MIN = tick_rem_t'(MAG_NEG_MIN % COUNTS_PER_DETENT);
  localparam tick_quo_t QUO_POS_MAX = tick_quo_t'(MAG_POS_MAX / COUNTS_PER_DETENT);
  localparam tick_rem_t REM_POS_MAX = tick_rem_t'(MAG_POS_MAX % COUNTS_PER_DETENT);
  localparam tick_quo_t QUO_ONE     = tick_quo_t'(1 / COUNTS_PER_DETENT);
  localparam tick_rem_t REM_ONE     = tick_rem_t'(1 % COUNTS_PER_DETENT);
  localparam tick_rem_t REM_LAST    = tick_rem_t'(COUNTS_PER_DETENT - 1);

  localparam tick_t TICK_ZERO = '{neg: 1'b0, quo: '0, rem: '0};

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_START  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ALARM_OK   = 2'd0,
    ALARM_LOW  = 2'd1,
    ALARM_HIGH = 2'd2
  } alarm_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REVERSE    = 2'd0,
    REG_LOW_LIMIT  = 2'd1,
    REG_HIGH_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // Indexed by previous state times four plus current state (A in bit 1).
  localparam step_t STEP_TABLE [16] = '{
    STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_HOLD,
    STEP_UP,   STEP_HOLD, STEP_HOLD, STEP_DOWN,
    STEP_DOWN, STEP_HOLD, STEP_HOLD, STEP_UP,
    STEP_HOLD, STEP_UP,   STEP_DOWN, STEP_HOLD
  };

  function automatic step_t step_lookup(input logic [1:0] prev_ab, input logic [1:0] curr_ab);
    return STEP_TABLE[{prev_ab, curr_ab}];
  endfunction

endpackage

@@ hw/rtl/qepl_in_if.sv @@
`timescale 1ns / 1ps

interface qepl_in_if import qepl_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t cmd;
  logic level_a;
  logic level_b;

  modport source (output valid, output cmd, output level_a, output level_b, input ready);
  modport sink   (input valid, input cmd, input level_a, input level_b, output ready);
endinterface

@@ hw/rtl/qepl_out_if.sv @@
`timescale 1ns / 1ps

interface qepl_out_if import qepl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  alarm_t                  alarm;

  modport source (output valid, output position, output alarm, input ready);
  modport sink   (input valid, input position, input alarm, output ready);
endinterface

@@ hw/rtl/qepl_cfg_if.sv @@
`timescale 1ns / 1ps

interface qepl_cfg_if import qepl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  reg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/quadrature_encoder_position_limits.sv @@
`timescale 1ns / 1ps
// Each read item gives one result. Throughput: one item per cycle while the
// input is ready (until both stages are full); sample, clear and start items
// update the tick counter at the edge that accepts them and give no result.
// Two result stages (position, then alarm and output) decouple the sides.
// Reset (rst_n low, synchronous) zeroes ticks and last state, empties both
// stages and restores reverse off, low limit minimum and high limit maximum.

module quadrature_encoder_position_limits import qepl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  qepl_in_if.sink    in_ch,
  qepl_out_if.source out_ch,
  qepl_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic                    reverse_r;
  logic signed [POS_W-1:0] low_limit_r;
  logic signed [POS_W-1:0] high_limit_r;

  // Decoder state.
  tick_t      tick_r,    tick_nxt;
  logic [1:0] last_ab_r, last_ab_nxt;
  logic [1:0] curr_ab;

  // Position stage and output stage.
  logic                    pos_valid_r, pos_valid_nxt;
  logic signed [POS_W-1:0] pos_r;
  logic signed [POS_W-1:0] pos_calc;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_position_r;
  alarm_t                  out_alarm_r;
  alarm_t                  alarm_calc;

  logic out_stage_ready;
  logic pos_stage_ready;
  logic in_fire;
  logic read_fire;

  // Detent conversion.
  logic [63:0]      quo_wide;
  logic             out_neg;
  logic [POS_W-1:0] mag_sat;

  // ---------------------------------------------------------------------
  // Handshake. Each stage takes a new item when it is empty or when the
  // stage after it is moving, so a waiting result holds the input back
  // only once both stages are full.
  // ---------------------------------------------------------------------
  assign out_stage_ready = !out_valid_r || out_ch.ready;
  assign pos_stage_ready = !pos_valid_r || out_stage_ready;
  assign in_ch.ready     = pos_stage_ready;
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign read_fire       = in_fire && (in_ch.cmd == CMD_READ);

  assign cfg_ch.ready    = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_position_r;
  assign out_ch.alarm    = out_alarm_r;

  // ---------------------------------------------------------------------
  // Tick counter arithmetic. The magnitude moves by one through the
  // remainder, carrying into the quotient, so the detent count is always
  // on hand without a divider. The two wrap points of the two's complement
  // counter (maximum to minimum and back) and the zero crossing flip the
  // sign with constant magnitudes worked out at elaboration.
  // ---------------------------------------------------------------------
  function automatic tick_t mag_up(input tick_t t);
    tick_t r;
    r = t;
    if (t.rem == REM_LAST) begin
      r.quo = t.quo + 1'b1;
      r.rem = '0;
    end else begin
      r.rem = t.rem + 1'b1;
    end
    return r;
  endfunction

  function automatic tick_t mag_down(input tick_t t);
    tick_t r;
    r = t;
    if (t.rem == '0) begin
      r.quo = t.quo - 1'b1;
      r.rem = REM_LAST;
    end else begin
      r.rem = t.rem - 1'b1;
    end
    return r;
  endfunction

  function automatic tick_t tick_up(input tick_t t);
    tick_t r;
    if (!t.neg) begin
      if (t.quo == QUO_POS_MAX && t.rem == REM_POS_MAX) begin
        r = '{neg: 1'b1, quo: QUO_NEG_MIN, rem: REM_NEG_MIN};
      end else begin
        r = mag_up(t);
      end
    end else begin
      if (t.quo == QUO_ONE && t.rem == REM_ONE) begin
        r = TICK_ZERO;
      end else begin
        r = mag_down(t);
      end
    end
    return r;
  endfunction

  function automatic tick_t tick_down(input tick_t t);
    tick_t r;
    if (!t.neg) begin
      if (t.quo == '0 && t.rem == '0) begin
        r = '{neg: 1'b1, quo: QUO_ONE, rem: REM_ONE};
      end else begin
        r = mag_down(t);
      end
    end else begin
      if (t.quo == QUO_NEG_MIN && t.rem == REM_NEG_MIN) begin
        r = '{neg: 1'b0, quo: QUO_POS_MAX, rem: REM_POS_MAX};
      end else begin
        r = mag_up(t);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Command decode and state update.
  // ---------------------------------------------------------------------
  assign curr_ab = {in_ch.level_a, in_ch.level_b};

  always_comb begin
    tick_nxt    = tick_r;
    last_ab_nxt = last_ab_r;
    if (in_fire) begin
      unique case (in_ch.cmd)
        CMD_SAMPLE: begin
          last_ab_nxt = curr_ab;
          unique case (step_lookup(last_ab_r, curr_ab))
            STEP_UP:   tick_nxt = tick_up(tick_r);
            STEP_DOWN: tick_nxt = tick_down(tick_r);
            default:   tick_nxt = tick_r;
          endcase
        end
        CMD_READ: begin
          tick_nxt = tick_r;
        end
        CMD_CLEAR: begin
          tick_nxt = TICK_ZERO;
        end
        CMD_START: begin
          last_ab_nxt = curr_ab;
          tick_nxt    = TICK_ZERO;
        end
        default: begin
          tick_nxt = tick_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Position: the quotient is the truncated detent count; saturate it to
  // the 32-bit signed range on the side the direction gives, then apply
  // the sign. A zero quotient reads as zero whatever the sign.
  // ---------------------------------------------------------------------
  assign quo_wide = 64'(tick_r.quo);
  assign out_neg  = tick_r.neg ^ reverse_r;

  always_comb begin
    if (out_neg) begin
      mag_sat  = (quo_wide > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : quo_wide[POS_W-1:0];
      pos_calc = POS_W'(32'd0 - mag_sat);
    end else begin
      mag_sat  = (quo_wide > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_wide[POS_W-1:0];
      pos_calc = mag_sat;
    end
  end

  // The low test wins when both limits apply.
  always_comb begin
    priority if (pos_r < low_limit_r) begin
      alarm_calc = ALARM_LOW;
    end else if (pos_r > high_limit_r) begin
      alarm_calc = ALARM_HIGH;
    end else begin
      alarm_calc = ALARM_OK;
    end
  end

  always_comb begin
    pos_valid_nxt = pos_valid_r;
    out_valid_nxt = out_valid_r;
    if (pos_stage_ready) begin
      pos_valid_nxt = read_fire;
    end
    if (out_stage_ready) begin
      out_valid_nxt = pos_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r    <= 1'b0;
      low_limit_r  <= {1'b1, {(POS_W-1){1'b0}}};
      high_limit_r <= {1'b0, {(POS_W-1){1'b1}}};
      tick_r       <= TICK_ZERO;
      last_ab_r    <= 2'b00;
      pos_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      last_ab_r   <= last_ab_nxt;
      pos_valid_r <= pos_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_REVERSE:    reverse_r    <= cfg_ch.data[0];
          REG_LOW_LIMIT:  low_limit_r  <= cfg_ch.data[POS_W-1:0];
          REG_HIGH_LIMIT: high_limit_r <= cfg_ch.data[POS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_stage_ready && read_fire) begin
      pos_r <= pos_calc;
    end
    if (out_stage_ready && pos_valid_r) begin
      out_position_r <= pos_r;
      out_alarm_r    <= alarm_calc;
    end
  end

endmodule

@@ hw/rtl/qepl_checker.sv @@
`timescale 1ns / 1ps

module qepl_checker import qepl_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input cmd_t                    in_cmd,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_position,
  input alarm_t                  out_alarm
);

  logic read_fire;

  assign read_fire = in_valid && in_ready && (in_cmd == CMD_READ);

  // Reset leaves no result pending and the input open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result pending or input closed after reset");

  // A read item is followed by a valid output after the position and output registers.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    read_fire |-> ##2 out_valid)
    else $error("read item gave no result in time");

  // Without a recent read no result can appear.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !read_fire && !$past(read_fire)) |=> !out_valid)
    else $error("result appeared without a read item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_position) && $stable(out_alarm)))
    else $error("stalled result changed");

endmodule

bind quadrature_encoder_position_limits qepl_checker u_qepl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_cmd       (in_ch.cmd),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_alarm    (out_ch.alarm)
);
